// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define DMTG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define DMTG_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/dmtg_pkg.sv =====
`default_nettype none
package dmtg_pkg;

	typedef longint unsigned u64_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 25;
	localparam int LEN_W       = 16;
	localparam int STEP_W      = 25;
	localparam int AMP_W       = 15;
	localparam int MAG_W       = 15;
	localparam int SAMPLE_W    = 17;
	localparam int PHASE_W     = 32;
	localparam int HZ_W        = 11;

	localparam logic [CFG_INDEX_W-1:0] CFG_TONE_SAMPLES   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CPAUSE_SAMPLES = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RPAUSE_SAMPLES = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE      = 3'd4;

	localparam logic [LEN_W-1:0]  TONE_SAMPLES_RST   = 16'd1600;
	localparam logic [LEN_W-1:0]  CPAUSE_SAMPLES_RST = 16'd1600;
	localparam logic [LEN_W-1:0]  RPAUSE_SAMPLES_RST = 16'd400;
	localparam logic [STEP_W-1:0] PHASE_STEP_RST     = 25'd536871;
	localparam logic [AMP_W-1:0]  AMPLITUDE_RST      = 15'd9830;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_INVALID = 2'd1;
	localparam status_t ST_BUSY    = 2'd2;

	typedef struct packed {
		logic    tone;
		status_t status;
		logic    busy;
		logic    done;
	} ctl_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] row;
		logic [1:0] col;
		logic [2:0] presses;
	} key_t;

	localparam longint C_A1 = 64'sd1686629713;
	localparam longint C_A3 = 64'sd693598668;
	localparam longint C_A5 = 64'sd85569305;
	localparam longint C_A7 = 64'sd5026995;
	localparam longint C_A9 = 64'sd172273;

	// Keypad lookup: button, then 1-based position on that button.
	function automatic key_t char_key(input logic [7:0] ch);
		key_t k;
		unique case (ch)
			"1": k = {1'b1, 2'd0, 2'd0, 3'd1};
			"a": k = {1'b1, 2'd0, 2'd1, 3'd1};
			"b": k = {1'b1, 2'd0, 2'd1, 3'd2};
			"c": k = {1'b1, 2'd0, 2'd1, 3'd3};
			"2": k = {1'b1, 2'd0, 2'd1, 3'd4};
			"d": k = {1'b1, 2'd0, 2'd2, 3'd1};
			"e": k = {1'b1, 2'd0, 2'd2, 3'd2};
			"f": k = {1'b1, 2'd0, 2'd2, 3'd3};
			"3": k = {1'b1, 2'd0, 2'd2, 3'd4};
			"g": k = {1'b1, 2'd1, 2'd0, 3'd1};
			"h": k = {1'b1, 2'd1, 2'd0, 3'd2};
			"i": k = {1'b1, 2'd1, 2'd0, 3'd3};
			"4": k = {1'b1, 2'd1, 2'd0, 3'd4};
			"j": k = {1'b1, 2'd1, 2'd1, 3'd1};
			"k": k = {1'b1, 2'd1, 2'd1, 3'd2};
			"l": k = {1'b1, 2'd1, 2'd1, 3'd3};
			"5": k = {1'b1, 2'd1, 2'd1, 3'd4};
			"m": k = {1'b1, 2'd1, 2'd2, 3'd1};
			"n": k = {1'b1, 2'd1, 2'd2, 3'd2};
			"o": k = {1'b1, 2'd1, 2'd2, 3'd3};
			"6": k = {1'b1, 2'd1, 2'd2, 3'd4};
			"p": k = {1'b1, 2'd2, 2'd0, 3'd1};
			"q": k = {1'b1, 2'd2, 2'd0, 3'd2};
			"r": k = {1'b1, 2'd2, 2'd0, 3'd3};
			"s": k = {1'b1, 2'd2, 2'd0, 3'd4};
			"7": k = {1'b1, 2'd2, 2'd0, 3'd5};
			"t": k = {1'b1, 2'd2, 2'd1, 3'd1};
			"u": k = {1'b1, 2'd2, 2'd1, 3'd2};
			"v": k = {1'b1, 2'd2, 2'd1, 3'd3};
			"8": k = {1'b1, 2'd2, 2'd1, 3'd4};
			"w": k = {1'b1, 2'd2, 2'd2, 3'd1};
			"x": k = {1'b1, 2'd2, 2'd2, 3'd2};
			"y": k = {1'b1, 2'd2, 2'd2, 3'd3};
			"z": k = {1'b1, 2'd2, 2'd2, 3'd4};
			"9": k = {1'b1, 2'd2, 2'd2, 3'd5};
			"#": k = {1'b1, 2'd3, 2'd0, 3'd1};
			".": k = {1'b1, 2'd3, 2'd0, 3'd2};
			"!": k = {1'b1, 2'd3, 2'd0, 3'd3};
			"?": k = {1'b1, 2'd3, 2'd0, 3'd4};
			",": k = {1'b1, 2'd3, 2'd0, 3'd5};
			" ": k = {1'b1, 2'd3, 2'd1, 3'd1};
			"0": k = {1'b1, 2'd3, 2'd1, 3'd2};
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [HZ_W-1:0] row_hz(input logic [1:0] r);
		logic [HZ_W-1:0] hz;
		unique case (r)
			2'd0: hz = 11'd697;
			2'd1: hz = 11'd770;
			2'd2: hz = 11'd852;
			default: hz = 11'd941;
		endcase
		return hz;
	endfunction

	function automatic logic [HZ_W-1:0] col_hz(input logic [1:0] c);
		logic [HZ_W-1:0] hz;
		unique case (c)
			2'd0: hz = 11'd1209;
			2'd1: hz = 11'd1336;
			2'd2: hz = 11'd1477;
			default: hz = 11'd0;
		endcase
		return hz;
	endfunction

	// Q30 sign-magnitude product with truncation toward zero.
	function automatic longint mulq30(input longint a, input longint b);
		u64_t ua;
		u64_t ub;
		longint p;
		ua = (a < 0) ? u64_t'(-a) : u64_t'(a);
		ub = (b < 0) ? u64_t'(-b) : u64_t'(b);
		p = longint'((ua * ub) >> 30);
		return ((a < 0) != (b < 0)) ? -p : p;
	endfunction

	// Quarter-wave entry k, evaluated at elaboration only.
	function automatic logic [MAG_W-1:0] quarter_entry(input int k, input int sib);
		longint x;
		longint x2;
		longint p;
		u64_t v;
		x  = longint'(k) <<< (32 - sib);
		x2 = mulq30(x, x);
		p  = C_A9;
		p  = mulq30(p, x2) - C_A7;
		p  = mulq30(p, x2) + C_A5;
		p  = mulq30(p, x2) - C_A3;
		p  = mulq30(p, x2) + C_A1;
		p  = mulq30(p, x);
		v  = 0;
		if (p > 0)
			v = (u64_t'(p) * 64'd32767 + 64'd536870912) >> 30;
		if (v > 64'd32767)
			v = 64'd32767;
		return v[MAG_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dmtg_if.sv =====
`default_nettype none
interface dmtg_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] char_code;
	logic       first_in_message;

	modport source(output valid, func, char_code, first_in_message, input ready);
	modport sink(input valid, func, char_code, first_in_message, output ready);
endinterface

interface dmtg_out_if;
	import dmtg_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	status_t                    status;
	logic                       busy_res;
	logic                       char_done;

	modport source(output valid, sample, status, busy_res, char_done, input ready);
	modport sink(input valid, sample, status, busy_res, char_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dtmf_multitap_tone_generator.sv =====
// An accepted transaction is registered in the front and the queue, then passes the back pipeline to out_ch.
// Throughput: one transaction per cycle while the queue has room; the keypad state is registered in the front
// and the sine lookup, sum-multiply and rounding run as a 3-stage back pipeline.
// A 4-entry queue between front and back absorbs output stalls before in_ch drops ready.
// Reset (arst_n low, asynchronous): idle state, phases and counters cleared, pipeline and
// queue emptied, configuration registers back to their default values.
`default_nettype none
module dtmf_multitap_tone_generator #(
	parameter int SINE_INDEX_BITS = 10,
	parameter int COUNT_BITS      = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	dmtg_in_if.sink                               in_ch,
	dmtg_out_if.source                            out_ch,
	input  wire logic                             cfg_wr_en,
	input  wire logic [dmtg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [dmtg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dmtg_pkg::*;

	localparam int Q_DEPTH = 4;
	localparam int Q_WIDTH = $bits(ctl_t) + 2 * SINE_INDEX_BITS;

	logic [AMP_W-1:0]           amplitude;
	logic                       push;
	logic                       q_ready;
	ctl_t                       f_ctl;
	logic [SINE_INDEX_BITS-1:0] f_row_idx, f_col_idx;
	logic                       q_valid;
	logic                       b_ready;
	logic [Q_WIDTH-1:0]         q_data;
	ctl_t                       b_ctl;
	logic [SINE_INDEX_BITS-1:0] b_row_idx, b_col_idx;

	dmtg_front #(
		.SINE_INDEX_BITS(SINE_INDEX_BITS),
		.COUNT_BITS     (COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.amplitude(amplitude),
		.in_ch    (in_ch),
		.q_ready  (q_ready),
		.push     (push),
		.ctl      (f_ctl),
		.row_idx  (f_row_idx),
		.col_idx  (f_col_idx)
	);

	dmtg_queue #(
		.WIDTH(Q_WIDTH),
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({f_ctl, f_row_idx, f_col_idx}),
		.ready    (q_ready),
		.pop      (q_valid && b_ready),
		.pop_data (q_data),
		.valid    (q_valid)
	);

	assign {b_ctl, b_row_idx, b_col_idx} = q_data;

	dmtg_back #(
		.SINE_INDEX_BITS(SINE_INDEX_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.amplitude(amplitude),
		.in_valid (q_valid),
		.in_ready (b_ready),
		.in_ctl   (b_ctl),
		.row_idx  (b_row_idx),
		.col_idx  (b_col_idx),
		.out_ch   (out_ch)
	);
endmodule
`default_nettype wire

// ===== rtl/core/dmtg_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module dmtg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  ready,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  valid
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign ready    = count_q != CNT_W'(DEPTH);
	assign valid    = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`DMTG_ASSERT_NEVER(a_queue_overflow, clk, arst_n, push && !pop && !ready, "queue overflow")
	`DMTG_ASSERT_NEVER(a_queue_underflow, clk, arst_n, pop && !valid, "queue underflow")
endmodule
`default_nettype wire

// ===== rtl/core/dmtg_front.sv =====
`default_nettype none
`include "assert_macros.svh"
module dmtg_front #(
	parameter int SINE_INDEX_BITS = 10,
	parameter int COUNT_BITS      = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [dmtg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [dmtg_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [dmtg_pkg::AMP_W-1:0]              amplitude,
	dmtg_in_if.sink                                 in_ch,
	input  wire logic                               q_ready,
	output logic                                    push,
	output dmtg_pkg::ctl_t                          ctl,
	output logic [SINE_INDEX_BITS-1:0]              row_idx,
	output logic [SINE_INDEX_BITS-1:0]              col_idx
);
	import dmtg_pkg::*;

	localparam int CMP_W  = (COUNT_BITS + 1 > LEN_W) ? COUNT_BITS + 1 : LEN_W;
	localparam int PROD_W = HZ_W + STEP_W;

	typedef enum logic [1:0] {
		KIND_IDLE,
		KIND_CPAUSE,
		KIND_TONE,
		KIND_RPAUSE
	} kind_t;

	logic [LEN_W-1:0]  tone_len_q;
	logic [LEN_W-1:0]  cpause_len_q;
	logic [LEN_W-1:0]  rpause_len_q;
	logic [STEP_W-1:0] step_q;
	logic [AMP_W-1:0]  amp_q;

	kind_t                  kind_q, kind_d;
	logic [1:0]             row_q, row_d;
	logic [1:0]             col_q, col_d;
	logic [2:0]             presses_q, presses_d;
	logic [COUNT_BITS-1:0]  count_q, count_d;
	logic [PHASE_W-1:0]     row_phase_q, row_phase_d;
	logic [PHASE_W-1:0]     col_phase_q, col_phase_d;

	key_t                  key;
	logic [COUNT_BITS:0]   cnt_next;
	logic [LEN_W-1:0]      seg_len;
	logic                  seg_ends;
	logic [PROD_W-1:0]     row_prod;
	logic [PROD_W-1:0]     col_prod;

	assign in_ch.ready = q_ready;
	assign push        = in_ch.valid && in_ch.ready;
	assign amplitude   = amp_q;
	assign row_idx     = row_phase_q[PHASE_W-1 -: SINE_INDEX_BITS];
	assign col_idx     = col_phase_q[PHASE_W-1 -: SINE_INDEX_BITS];

	assign key      = char_key(in_ch.char_code);
	assign cnt_next = {1'b0, count_q} + 1'b1;
	assign seg_len  = (kind_q == KIND_CPAUSE) ? cpause_len_q :
		(kind_q == KIND_RPAUSE) ? rpause_len_q : tone_len_q;
	// A segment also ends when the counter would wrap.
	assign seg_ends = (CMP_W'(cnt_next) >= CMP_W'(seg_len)) || cnt_next[COUNT_BITS];
	assign row_prod = PROD_W'(row_hz(row_q)) * PROD_W'(step_q);
	assign col_prod = PROD_W'(col_hz(col_q)) * PROD_W'(step_q);

	always_comb begin
		kind_d      = kind_q;
		row_d       = row_q;
		col_d       = col_q;
		presses_d   = presses_q;
		count_d     = count_q;
		row_phase_d = row_phase_q;
		col_phase_d = col_phase_q;
		ctl.tone    = 1'b0;
		ctl.status  = ST_OK;
		ctl.done    = 1'b0;
		if (in_ch.func == FUNC_LOAD) begin
			if (kind_q != KIND_IDLE) begin
				ctl.status = ST_BUSY;
			end else if (!key.valid) begin
				ctl.status = ST_INVALID;
			end else begin
				row_d     = key.row;
				col_d     = key.col;
				presses_d = key.presses;
				count_d   = '0;
				if (in_ch.first_in_message || cpause_len_q == '0) begin
					kind_d      = KIND_TONE;
					row_phase_d = '0;
					col_phase_d = '0;
				end else begin
					kind_d = KIND_CPAUSE;
				end
			end
		end else begin
			unique case (kind_q)
				KIND_IDLE: begin
				end
				KIND_CPAUSE, KIND_RPAUSE: begin
					if (seg_ends) begin
						kind_d      = KIND_TONE;
						count_d     = '0;
						row_phase_d = '0;
						col_phase_d = '0;
					end else begin
						count_d = cnt_next[COUNT_BITS-1:0];
					end
				end
				KIND_TONE: begin
					ctl.tone    = 1'b1;
					row_phase_d = row_phase_q + row_prod[PHASE_W-1:0];
					col_phase_d = col_phase_q + col_prod[PHASE_W-1:0];
					if (!seg_ends) begin
						count_d = cnt_next[COUNT_BITS-1:0];
					end else if (presses_q <= 3'd1) begin
						presses_d = '0;
						kind_d    = KIND_IDLE;
						count_d   = '0;
						ctl.done  = 1'b1;
					end else begin
						presses_d = presses_q - 1'b1;
						count_d   = '0;
						if (rpause_len_q == '0) begin
							row_phase_d = '0;
							col_phase_d = '0;
						end else begin
							kind_d = KIND_RPAUSE;
						end
					end
				end
				default: begin
				end
			endcase
		end
		ctl.busy = kind_d != KIND_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_len_q   <= TONE_SAMPLES_RST;
			cpause_len_q <= CPAUSE_SAMPLES_RST;
			rpause_len_q <= RPAUSE_SAMPLES_RST;
			step_q       <= PHASE_STEP_RST;
			amp_q        <= AMPLITUDE_RST;
			kind_q       <= KIND_IDLE;
			row_q        <= '0;
			col_q        <= '0;
			presses_q    <= '0;
			count_q      <= '0;
			row_phase_q  <= '0;
			col_phase_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_TONE_SAMPLES:   tone_len_q   <= cfg_data[LEN_W-1:0];
					CFG_CPAUSE_SAMPLES: cpause_len_q <= cfg_data[LEN_W-1:0];
					CFG_RPAUSE_SAMPLES: rpause_len_q <= cfg_data[LEN_W-1:0];
					CFG_PHASE_STEP:     step_q       <= cfg_data[STEP_W-1:0];
					CFG_AMPLITUDE:      amp_q        <= cfg_data[AMP_W-1:0];
					default: begin
					end
				endcase
			end
			if (push) begin
				kind_q      <= kind_d;
				row_q       <= row_d;
				col_q       <= col_d;
				presses_q   <= presses_d;
				count_q     <= count_d;
				row_phase_q <= row_phase_d;
				col_phase_q <= col_phase_d;
			end
		end
	end

	`DMTG_ASSERT(a_front_presses, clk, arst_n, kind_q != KIND_IDLE |-> presses_q != '0, "no presses left in an active segment")
	`DMTG_ASSERT(a_front_done_idle, clk, arst_n, push && ctl.done |=> kind_q == KIND_IDLE, "character done but not idle")
endmodule
`default_nettype wire

// ===== rtl/core/dmtg_back.sv =====
`default_nettype none
module dmtg_back #(
	parameter int SINE_INDEX_BITS = 10
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [dmtg_pkg::AMP_W-1:0]    amplitude,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire dmtg_pkg::ctl_t                in_ctl,
	input  wire logic [SINE_INDEX_BITS-1:0]    row_idx,
	input  wire logic [SINE_INDEX_BITS-1:0]    col_idx,
	dmtg_out_if.source                         out_ch
);
	import dmtg_pkg::*;

	localparam int QLEN   = 1 << (SINE_INDEX_BITS - 2);
	localparam int ADDR_W = SINE_INDEX_BITS - 1;
	localparam int PROD_W = AMP_W + SAMPLE_W + 1;

	logic [MAG_W-1:0] rom [QLEN + 1];

	for (genvar k = 0; k <= QLEN; k++) begin : g_rom
		assign rom[k] = quarter_entry(k, SINE_INDEX_BITS);
	end

	logic [1:0]        row_quad, col_quad;
	logic [ADDR_W-1:0] row_k, col_k;
	logic [ADDR_W-1:0] row_addr, col_addr;
	logic              en;

	logic                       v_s1, v_s2, v_s3;
	ctl_t                       ctl_s1, ctl_s2, ctl_s3;
	logic [MAG_W-1:0]           rmag_s1, cmag_s1;
	logic                       rneg_s1, cneg_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [SAMPLE_W-1:0] sample_s3;

	logic signed [SAMPLE_W-1:0] rs_c, cs_c, sum_c;
	logic signed [PROD_W-1:0]   prod_c;
	logic [PROD_W-1:0]          mag_c;
	logic [PROD_W-1:0]          rnd_c;
	logic signed [SAMPLE_W-1:0] smp_c;

	// Mirror the index in odd quadrants; the table holds QLEN+1 entries.
	assign row_quad = row_idx[SINE_INDEX_BITS-1 -: 2];
	assign col_quad = col_idx[SINE_INDEX_BITS-1 -: 2];
	assign row_k    = {1'b0, row_idx[SINE_INDEX_BITS-3:0]};
	assign col_k    = {1'b0, col_idx[SINE_INDEX_BITS-3:0]};
	assign row_addr = row_quad[0] ? ADDR_W'(QLEN) - row_k : row_k;
	assign col_addr = col_quad[0] ? ADDR_W'(QLEN) - col_k : col_k;

	assign en       = !v_s3 || out_ch.ready;
	assign in_ready = en;

	assign rs_c   = rneg_s1 ? -$signed({2'b00, rmag_s1}) : $signed({2'b00, rmag_s1});
	assign cs_c   = cneg_s1 ? -$signed({2'b00, cmag_s1}) : $signed({2'b00, cmag_s1});
	assign sum_c  = rs_c + cs_c;
	assign prod_c = $signed({1'b0, amplitude}) * sum_c;

	// Round half away from zero on the magnitude.
	assign mag_c = prod_s2[PROD_W-1] ? PROD_W'(-prod_s2) : PROD_W'(prod_s2);
	assign rnd_c = (mag_c + PROD_W'(16384)) >> 15;
	assign smp_c = prod_s2[PROD_W-1] ? -$signed(rnd_c[SAMPLE_W-1:0])
		: $signed(rnd_c[SAMPLE_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1    <= in_ctl;
			rmag_s1   <= rom[row_addr];
			cmag_s1   <= rom[col_addr];
			rneg_s1   <= row_quad[1];
			cneg_s1   <= col_quad[1];
			ctl_s2    <= ctl_s1;
			prod_s2   <= prod_c;
			ctl_s3    <= ctl_s2;
			sample_s3 <= ctl_s2.tone ? smp_c : '0;
		end
	end

	assign out_ch.valid     = v_s3;
	assign out_ch.sample    = sample_s3;
	assign out_ch.status    = ctl_s3.status;
	assign out_ch.busy_res  = ctl_s3.busy;
	assign out_ch.char_done = ctl_s3.done;
endmodule
`default_nettype wire
